// File: rtl/core/cbf_pkg.sv
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared constants and types for the comment blanking filter.
// ----------------------------------------------------------------------------
`default_nettype none

package cbf_pkg;

  // characters
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;

  // scan modes
  localparam int unsigned MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_NORMAL     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LINE       = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BLOCK      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BLOCK_STAR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STRING     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_STRING_ESC = 3'd5;

  // final status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BLOCK  = 2'd1;
  localparam logic [1:0] ST_STRING = 2'd2;

  // output queue
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QDEPTH = 1 << QPTR_W;
  localparam int unsigned QCNT_W = QPTR_W + 1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } res_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) || (b == CH_VT) || (b == CH_FF);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/comment_blanking_filter.sv
// ----------------------------------------------------------------------------
// comment_blanking_filter
// Blanks C-style comments out of a byte stream, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with in_byte and in_last; in_last marks the
// final byte of a text. Output channel: out_valid/out_stall with out_byte,
// out_last and status; status is nonzero only on the out_last beat.
// Each input beat yields one output beat, except that a slash in normal text
// that is not the final byte is held for one byte of lookahead: the slash
// beat yields none and the next beat yields two. Results are registered in
// a 4-entry output queue. The block takes one input beat per cycle while
// in_stall is low; the queue drains one beat per cycle while out_stall is
// low, and in_stall rises when fewer than two entries are free. A stall on
// the output side fills the queue and then stalls the input side; queued
// beats hold until taken. Reset empties the queue and returns the scanner
// to normal text with no slash pending; the scanner, not the queue, is reset
// likewise after every in_last beat, so the next beat starts a new text.
// ----------------------------------------------------------------------------
`default_nettype none

module comment_blanking_filter
  import cbf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic [1:0]      status
);

  logic [MODE_W-1:0] mode;
  logic [MODE_W-1:0] mode_next;
  logic              held_slash;
  logic              held_slash_next;

  res_t              queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic              in_acc;
  logic              pop;
  logic [7:0]        b;
  logic [MODE_W-1:0] mode_w;
  logic [MODE_W-1:0] base_mode;
  logic              pre_valid;
  logic [7:0]        pre_byte;
  logic              res_valid;
  logic [7:0]        res_byte;
  logic              hold;
  logic [1:0]        res_status;
  logic [1:0]        push_n;
  logic [QPTR_W-1:0] wr_ptr2;

  assign in_stall  = (count > QCNT_W'(QDEPTH - 2));
  assign out_valid = (count != '0);
  assign in_acc    = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  assign out_byte  = queue[rd_ptr].data;
  assign out_last  = queue[rd_ptr].last;
  assign status    = queue[rd_ptr].status;

  // scanner
  always_comb begin
    b         = (in_byte == CH_CR) ? CH_SP : in_byte;
    mode_w    = mode;
    pre_valid = 1'b0;
    pre_byte  = CH_SLASH;
    res_valid = 1'b1;
    res_byte  = b;
    hold      = 1'b0;
    base_mode = held_slash ? MODE_NORMAL : mode;
    if (held_slash) begin
      pre_valid = 1'b1;
      pre_byte  = ((b == CH_SLASH) || (b == CH_STAR)) ? CH_SP : CH_SLASH;
    end
    if (held_slash && ((b == CH_SLASH) || (b == CH_STAR))) begin
      mode_w   = (b == CH_SLASH) ? MODE_LINE : MODE_BLOCK_STAR;
      res_byte = CH_SP;
    end else begin
      case (base_mode)
        MODE_LINE: begin
          if (b == CH_LF) begin
            mode_w = MODE_NORMAL;
          end else begin
            res_byte = CH_SP;
          end
        end
        MODE_BLOCK, MODE_BLOCK_STAR: begin
          if ((base_mode == MODE_BLOCK_STAR) && (b == CH_SLASH)) begin
            mode_w = MODE_NORMAL;
          end else if (b == CH_STAR) begin
            mode_w = MODE_BLOCK_STAR;
          end else begin
            mode_w = MODE_BLOCK;
          end
          res_byte = is_blank(b) ? b : CH_SP;
        end
        MODE_STRING: begin
          if (b == CH_BSLASH) begin
            mode_w = MODE_STRING_ESC;
          end else if (b == CH_QUOTE) begin
            mode_w = MODE_NORMAL;
          end
        end
        MODE_STRING_ESC: begin
          mode_w = MODE_STRING;
        end
        default: begin
          mode_w = MODE_NORMAL;
          if ((b == CH_SLASH) && !in_last) begin
            hold      = 1'b1;
            res_valid = 1'b0;
          end else if (b == CH_QUOTE) begin
            mode_w = MODE_STRING;
          end
        end
      endcase
    end

    res_status = ST_OK;
    if (in_last) begin
      if ((mode_w == MODE_BLOCK) || (mode_w == MODE_BLOCK_STAR)) begin
        res_status = ST_BLOCK;
      end else if ((mode_w == MODE_STRING) || (mode_w == MODE_STRING_ESC)) begin
        res_status = ST_STRING;
      end
    end

    mode_next       = in_last ? MODE_NORMAL : mode_w;
    held_slash_next = in_last ? 1'b0 : hold;
    push_n          = {1'b0, pre_valid} + {1'b0, res_valid};
    wr_ptr2         = wr_ptr + QPTR_W'(pre_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      held_slash <= 1'b0;
    end else if (in_acc) begin
      mode       <= mode_next;
      held_slash <= held_slash_next;
    end
  end

  // output queue
  always_ff @(posedge clk) begin
    if (in_acc && pre_valid) begin
      queue[wr_ptr] <= '{data: pre_byte, last: 1'b0, status: ST_OK};
    end
    if (in_acc && res_valid) begin
      queue[wr_ptr2] <= '{data: res_byte, last: in_last, status: res_status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr <= wr_ptr + QPTR_W'(push_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (in_acc ? QCNT_W'(push_n) : '0) - QCNT_W'(pop);
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("output queue overflow");

  a_held_in_normal: assert property (@(posedge clk) disable iff (rst)
    held_slash |-> (mode == MODE_NORMAL))
    else $error("slash held outside normal text");

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_last) |=> (!held_slash && (mode == MODE_NORMAL)))
    else $error("scanner not back to normal after final beat");

  a_status_only_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (status == ST_OK))
    else $error("status reported on a non-final beat");

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams short texts through the comment blanking filter and checks every
// output beat against a scanner model kept in step with the accepted input.
// ----------------------------------------------------------------------------
module testbench;
  import cbf_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } src_beat_t;

  localparam int WATCHDOG_LIMIT = 3000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic [1:0] status;

  src_beat_t source_beats [$];
  res_t      blanked_q [$];

  logic [MODE_W-1:0] scan_state = MODE_NORMAL;
  logic              slash_held = 1'b0;

  int mismatch_count = 0;
  int beats_sent = 0;
  int beats_taken = 0;
  int burst_left = 0;
  int gap_left = 0;
  logic draining = 1'b0;
  int style_timer = 0;
  int stall_style = 0;
  int holdoff_left = 0;
  logic holdoff_done = 1'b0;
  int idle_cycles = 0;

  comment_blanking_filter DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .status    (status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic add_beat(input logic [7:0] data, input logic last);
    src_beat_t s;
    s.data = data;
    s.last = last;
    source_beats = {source_beats, s};
  endtask

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 10))
      0: return CH_SLASH;
      1: return CH_STAR;
      2: return CH_QUOTE;
      3: return CH_BSLASH;
      4: return CH_LF;
      5: return CH_CR;
      6: return CH_SP;
      7: return CH_TAB;
      8: return CH_VT;
      9: return CH_FF;
      default: return 8'h61;
    endcase
  endfunction

  function automatic logic [7:0] pick_any();
    if ($urandom_range(0, 2) == 0) return pick_special();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_expected(input logic [7:0] data, input logic last, input logic [1:0] st);
    res_t r;
    r.data = data;
    r.last = last;
    r.status = st;
    blanked_q = {blanked_q, r};
  endtask

  // one byte in the current mode, no slash pending
  task automatic scan_byte(input logic [7:0] b, input logic fin,
                           output logic [7:0] res, output logic emit);
    emit = 1'b1;
    res = b;
    case (scan_state)
      MODE_LINE: begin
        if (b == CH_LF) scan_state = MODE_NORMAL;
        else res = CH_SP;
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        if (scan_state == MODE_BLOCK_STAR && b == CH_SLASH) scan_state = MODE_NORMAL;
        else if (b == CH_STAR) scan_state = MODE_BLOCK_STAR;
        else scan_state = MODE_BLOCK;
        if (!(b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_VT || b == CH_FF))
          res = CH_SP;
      end
      MODE_STRING: begin
        if (b == CH_BSLASH) scan_state = MODE_STRING_ESC;
        else if (b == CH_QUOTE) scan_state = MODE_NORMAL;
      end
      MODE_STRING_ESC: begin
        scan_state = MODE_STRING;
      end
      default: begin
        scan_state = MODE_NORMAL;
        if (b == CH_SLASH && !fin) begin
          slash_held = 1'b1;
          emit = 1'b0;
        end else if (b == CH_QUOTE) begin
          scan_state = MODE_STRING;
        end
      end
    endcase
  endtask

  task automatic predict_blanking(input logic [7:0] raw, input logic fin);
    logic [7:0] b;
    logic [7:0] res;
    logic       emit;
    logic [1:0] st;
    b = (raw == CH_CR) ? CH_SP : raw;
    if (slash_held) begin
      slash_held = 1'b0;
      if (b == CH_SLASH || b == CH_STAR) begin
        push_expected(CH_SP, 1'b0, ST_OK);
        scan_state = (b == CH_SLASH) ? MODE_LINE : MODE_BLOCK_STAR;
        res = CH_SP;
        emit = 1'b1;
      end else begin
        push_expected(CH_SLASH, 1'b0, ST_OK);
        scan_state = MODE_NORMAL;
        scan_byte(b, fin, res, emit);
      end
    end else begin
      scan_byte(b, fin, res, emit);
    end
    st = ST_OK;
    if (fin) begin
      if (scan_state == MODE_BLOCK || scan_state == MODE_BLOCK_STAR) st = ST_BLOCK;
      else if (scan_state == MODE_STRING || scan_state == MODE_STRING_ESC) st = ST_STRING;
    end
    if (emit) push_expected(res, fin, st);
    if (fin) begin
      scan_state = MODE_NORMAL;
      slash_held = 1'b0;
    end
  endtask

  // sender
  always @(posedge clk) begin
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    logic       nxt_last;
    src_beat_t  s;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_byte = in_byte;
      nxt_last = in_last;
      if (in_valid && !in_stall) begin
        predict_blanking(in_byte, in_last);
        beats_sent++;
        nxt_valid = 1'b0;
        if (beats_sent == 350 || beats_sent == 750) draining = 1'b1;
      end
      if (draining && blanked_q.size() == 0) draining = 1'b0;
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!draining && source_beats.size() != 0) begin
          s = source_beats.pop_front();
          nxt_valid = 1'b1;
          nxt_byte = s.data;
          nxt_last = s.last;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_valid <= nxt_valid;
      in_byte <= nxt_byte;
      in_last <= nxt_last;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    logic nxt_stall;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      style_timer++;
      if (style_timer >= 64) begin
        style_timer = 0;
        stall_style = $urandom_range(0, 4);
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        nxt_stall = 1'b1;
      end else if (!holdoff_done && beats_taken >= 200) begin
        holdoff_done = 1'b1;
        holdoff_left = 300;
        nxt_stall = 1'b1;
      end else begin
        case (stall_style)
          0: nxt_stall = 1'b0;
          1: nxt_stall = ($urandom_range(0, 3) == 0);
          2: nxt_stall = ($urandom_range(0, 3) != 0);
          3: nxt_stall = ~out_stall;
          default: nxt_stall = (style_timer[4:3] == 2'b11);
        endcase
      end
      out_stall <= nxt_stall;
    end
  end

  // output checker
  always @(posedge clk) begin
    res_t exp_beat;
    if (!rst && out_valid && !out_stall) begin
      beats_taken++;
      if (blanked_q.size() == 0) begin
        $display("%0t unexpected beat: byte %h last %b status %0d",
                 $time, out_byte, out_last, status);
        mismatch_count++;
      end else begin
        exp_beat = blanked_q.pop_front();
        if (out_byte !== exp_beat.data) begin
          $display("%0t out_byte expected %h actual %h", $time, exp_beat.data, out_byte);
          mismatch_count++;
        end
        if (out_last !== exp_beat.last) begin
          $display("%0t out_last expected %b actual %b", $time, exp_beat.last, out_last);
          mismatch_count++;
        end
        if (status !== exp_beat.status) begin
          $display("%0t status expected %0d actual %0d", $time, exp_beat.status, status);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] txt [$];
    int goal;
    // slash-star-slash closes at once
    add_beat(CH_SLASH, 1'b0); add_beat(CH_STAR, 1'b0); add_beat(CH_SLASH, 1'b0);
    add_beat(8'h62, 1'b1);
    // held slash released, then line comment open at end with carriage return
    add_beat(CH_SLASH, 1'b0); add_beat(8'h78, 1'b0); add_beat(CH_SLASH, 1'b0);
    add_beat(CH_SLASH, 1'b0); add_beat(CH_CR, 1'b1);
    // string with escape, backslash as final byte
    add_beat(CH_QUOTE, 1'b0); add_beat(CH_BSLASH, 1'b0); add_beat(CH_QUOTE, 1'b0);
    add_beat(8'hFF, 1'b0); add_beat(CH_BSLASH, 1'b1);
    // unclosed block comment
    add_beat(CH_SLASH, 1'b0); add_beat(CH_STAR, 1'b0); add_beat(CH_TAB, 1'b0);
    add_beat(8'h00, 1'b0); add_beat(CH_STAR, 1'b1);
    // slash as the final byte
    add_beat(CH_SLASH, 1'b1);
    // held slash then quote, string left open
    add_beat(8'h80, 1'b0); add_beat(CH_SLASH, 1'b0); add_beat(CH_QUOTE, 1'b1);
    // line comment ended by its newline
    add_beat(CH_SLASH, 1'b0); add_beat(CH_SLASH, 1'b0); add_beat(CH_LF, 1'b1);

    while (source_beats.size() < 1075) begin
      txt.delete();
      goal = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
      while (txt.size() < goal) begin
        case ($urandom_range(0, 6))
          0: repeat ($urandom_range(1, 4)) txt = {txt, 8'($urandom_range(8'h21, 8'h7E))};
          1: begin
            txt = {txt, CH_SLASH};
            txt = {txt, CH_SLASH};
            repeat ($urandom_range(0, 5)) txt = {txt, pick_any()};
            if ($urandom_range(0, 3) != 0) txt = {txt, CH_LF};
          end
          2: begin
            txt = {txt, CH_SLASH};
            txt = {txt, CH_STAR};
            repeat ($urandom_range(0, 6)) txt = {txt, pick_any()};
            if ($urandom_range(0, 3) != 0) txt = {txt, CH_STAR};
            txt = {txt, CH_SLASH};
          end
          3: begin
            txt = {txt, CH_QUOTE};
            repeat ($urandom_range(0, 5)) begin
              if ($urandom_range(0, 3) == 0) txt = {txt, CH_BSLASH};
              txt = {txt, pick_any()};
            end
            txt = {txt, CH_QUOTE};
          end
          4: begin
            txt = {txt, CH_SLASH};
            txt = {txt, pick_any()};
          end
          5: repeat ($urandom_range(1, 3)) txt = {txt, 8'($urandom_range(0, 255))};
          default: txt = {txt, pick_special()};
        endcase
      end
      if ($urandom_range(0, 2) == 0)
        while (txt.size() > goal) txt.pop_back();
      foreach (txt[i]) add_beat(txt[i], i == txt.size() - 1);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (source_beats.size() != 0 || in_valid || blanked_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/cbf_pkg.sv
rtl/core/comment_blanking_filter.sv
bench/testbench.sv
